FILE: rtl/xsid_pkg.sv
package xsid_pkg;

  localparam int unsigned AddrWidth   = 20;
  localparam int unsigned TargetWidth = 22;
  localparam int unsigned ImmWidth    = 16;
  localparam int unsigned OutWidth    = 72;
  localparam int unsigned KindWidth   = 4;

  typedef enum logic [KindWidth-1:0] {
    KIND_DATA  = 4'd0,
    KIND_NOP   = 4'd1,
    KIND_RET   = 4'd2,
    KIND_RETF  = 4'd3,
    KIND_INT3  = 4'd4,
    KIND_INTN  = 4'd5,
    KIND_INC   = 4'd6,
    KIND_DEC   = 4'd7,
    KIND_PUSH  = 4'd8,
    KIND_POP   = 4'd9,
    KIND_MOV8  = 4'd10,
    KIND_MOV16 = 4'd11,
    KIND_CALL  = 4'd12,
    KIND_JMPN  = 4'd13,
    KIND_JMPS  = 4'd14,
    KIND_JCC   = 4'd15
  } kind_e;

  localparam logic [7:0] OP_NOP      = 8'h90;
  localparam logic [7:0] OP_RET      = 8'hc3;
  localparam logic [7:0] OP_RETF     = 8'hcb;
  localparam logic [7:0] OP_INT3     = 8'hcc;
  localparam logic [7:0] OP_INTN     = 8'hcd;
  localparam logic [7:0] OP_CALL     = 8'he8;
  localparam logic [7:0] OP_JMPN     = 8'he9;
  localparam logic [7:0] OP_JMPS     = 8'heb;
  localparam logic [7:0] OP_JCC_LO   = 8'h70;
  localparam logic [7:0] OP_JCC_HI   = 8'h7f;
  localparam logic [7:0] OP_MOV8_LO  = 8'hb0;
  localparam logic [7:0] OP_MOV8_HI  = 8'hb7;
  localparam logic [7:0] OP_MOV16_LO = 8'hb8;
  localparam logic [7:0] OP_MOV16_HI = 8'hbf;
  localparam logic [7:0] OP_INC_LO   = 8'h40;
  localparam logic [7:0] OP_INC_HI   = 8'h47;
  localparam logic [7:0] OP_DEC_LO   = 8'h48;
  localparam logic [7:0] OP_DEC_HI   = 8'h4f;
  localparam logic [7:0] OP_PUSH_LO  = 8'h50;
  localparam logic [7:0] OP_PUSH_HI  = 8'h57;
  localparam logic [7:0] OP_POP_LO   = 8'h58;
  localparam logic [7:0] OP_POP_HI   = 8'h5f;

  // tdata bit positions of the result fields
  localparam int unsigned AddrLsb   = 0;
  localparam int unsigned RegLsb    = 20;
  localparam int unsigned CondLsb   = 23;
  localparam int unsigned ImmLsb    = 27;
  localparam int unsigned TargetLsb = 43;

  function automatic logic [1:0] operand_count(input logic [7:0] op);
    logic [1:0] n;
    n = 2'd0;
    if (op == OP_INTN || op == OP_JMPS) n = 2'd1;
    if (op >= OP_MOV8_LO && op <= OP_MOV8_HI) n = 2'd1;
    if (op >= OP_JCC_LO && op <= OP_JCC_HI) n = 2'd1;
    if (op >= OP_MOV16_LO && op <= OP_MOV16_HI) n = 2'd2;
    if (op == OP_CALL || op == OP_JMPN) n = 2'd2;
    return n;
  endfunction

endpackage

FILE: rtl/x86_subset_insn_decoder.sv
// An accepted code byte is held in the input register; its result is registered in the output register.
// Throughput: one code byte per cycle; input stalls only while both registers are full and the result is not taken.
// Operand bytes give no result; the instruction record leaves with its last byte.
// Reset clears the byte offset, the operand collection state, image_length and both
// valid flags; configuration is always ready.
module x86_subset_insn_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [19:0] cfg_data_i,      // image_length
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,    // code_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [xsid_pkg::OutWidth-1:0]  m_axis_tdata,
  // insn_address[19:0], reg_index[22:20], cond_code[26:23], immediate[42:27],
  // branch_target[64:43], zeros above
  output logic [xsid_pkg::KindWidth-1:0] m_axis_tuser   // insn_kind[3:0]
);
  import xsid_pkg::*;

  logic [AddrWidth-1:0]   len_q;
  logic [AddrWidth-1:0]   off_q, off_d;
  logic [1:0]             pend_q, pend_d;
  logic [7:0]             held_op_q, held_op_d;
  logic [7:0]             held_lo_q, held_lo_d;
  logic [AddrWidth-1:0]   held_addr_q, held_addr_d;
  logic                   in_valid_q;
  logic [7:0]             in_byte_q;
  logic                   out_valid_q;
  logic [OutWidth-1:0]    out_data_q;
  kind_e                  out_kind_q;

  logic                   adv;
  logic                   proc;
  logic                   res_valid;
  kind_e                  res_kind;
  logic [2:0]             res_reg;
  logic [3:0]             res_cond;
  logic [ImmWidth-1:0]    res_imm;
  logic [TargetWidth-1:0] res_target;
  logic [1:0]             need;
  logic                   fits;
  logic [15:0]            word;
  logic [TargetWidth-1:0] base;
  logic [TargetWidth-1:0] d8;
  logic [TargetWidth-1:0] d16;

  assign cfg_ready_o   = 1'b1;
  assign adv           = !out_valid_q || m_axis_tready;
  assign proc          = in_valid_q && adv;
  assign s_axis_tready = !in_valid_q || adv;

  assign need = operand_count(in_byte_q);
  assign fits = ({1'b0, off_q} + 21'd1 + {19'd0, need}) <= {1'b0, len_q};
  assign word = {in_byte_q, held_lo_q};
  assign base = {2'b00, held_addr_q};
  assign d8   = {{(TargetWidth-8){in_byte_q[7]}}, in_byte_q};
  assign d16  = {{(TargetWidth-16){word[15]}}, word};

  always_comb begin
    off_d       = off_q;
    pend_d      = pend_q;
    held_op_d   = held_op_q;
    held_lo_d   = held_lo_q;
    held_addr_d = held_addr_q;
    res_valid   = 1'b0;
    res_kind    = KIND_DATA;
    res_reg     = '0;
    res_cond    = '0;
    res_imm     = '0;
    res_target  = '0;
    if (proc && (off_q < len_q)) begin
      off_d = off_q + 20'd1;
      if (pend_q == 2'd2) begin
        held_lo_d = in_byte_q;
        pend_d    = 2'd1;
      end else if (pend_q != 2'd0) begin
        pend_d    = 2'd0;
        res_valid = 1'b1;
        unique case (held_op_q) inside
          OP_INTN: begin
            res_kind = KIND_INTN;
            res_imm  = {8'd0, in_byte_q};
          end
          OP_JMPS: begin
            res_kind   = KIND_JMPS;
            res_target = base + 22'd2 + d8;
          end
          [OP_MOV8_LO:OP_MOV8_HI]: begin
            res_kind = KIND_MOV8;
            res_reg  = held_op_q[2:0];
            res_imm  = {8'd0, in_byte_q};
          end
          [OP_JCC_LO:OP_JCC_HI]: begin
            res_kind   = KIND_JCC;
            res_cond   = held_op_q[3:0];
            res_target = base + 22'd2 + d8;
          end
          [OP_MOV16_LO:OP_MOV16_HI]: begin
            res_kind = KIND_MOV16;
            res_reg  = held_op_q[2:0];
            res_imm  = word;
          end
          OP_CALL: begin
            res_kind   = KIND_CALL;
            res_target = base + 22'd3 + d16;
          end
          default: begin
            res_kind   = KIND_JMPN;
            res_target = base + 22'd3 + d16;
          end
        endcase
      end else if (need != 2'd0 && fits) begin
        held_op_d   = in_byte_q;
        held_addr_d = off_q;
        held_lo_d   = 8'd0;
        pend_d      = need;
      end else begin
        res_valid = 1'b1;
        unique case (in_byte_q) inside
          OP_NOP:                 res_kind = KIND_NOP;
          OP_RET:                 res_kind = KIND_RET;
          OP_RETF:                res_kind = KIND_RETF;
          OP_INT3:                res_kind = KIND_INT3;
          [OP_INC_LO:OP_INC_HI]:  res_kind = KIND_INC;
          [OP_DEC_LO:OP_DEC_HI]:  res_kind = KIND_DEC;
          [OP_PUSH_LO:OP_PUSH_HI]: res_kind = KIND_PUSH;
          [OP_POP_LO:OP_POP_HI]:  res_kind = KIND_POP;
          default: begin
            res_kind = KIND_DATA;
            res_imm  = {8'd0, in_byte_q};
          end
        endcase
        if (in_byte_q >= OP_INC_LO && in_byte_q <= OP_POP_HI) begin
          res_reg = in_byte_q[2:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      off_q       <= '0;
      pend_q      <= '0;
      held_op_q   <= '0;
      held_lo_q   <= '0;
      held_addr_q <= '0;
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        len_q <= cfg_data_i;
      end
      off_q       <= off_d;
      pend_q      <= pend_d;
      held_op_q   <= held_op_d;
      held_lo_q   <= held_lo_d;
      held_addr_q <= held_addr_d;
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (adv) begin
        out_valid_q <= proc && res_valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
    end
    if (proc && res_valid) begin
      out_kind_q <= res_kind;
      out_data_q <= {{(OutWidth-TargetLsb-TargetWidth){1'b0}}, res_target, res_imm,
                     res_cond, res_reg, held_addr_d == held_addr_q && pend_q != 2'd0 ?
                     held_addr_q : off_q};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_kind_q;

endmodule

FILE: rtl/xsid_checker.sv
module xsid_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [xsid_pkg::OutWidth-1:0]  m_axis_tdata,
  input logic [xsid_pkg::KindWidth-1:0] m_axis_tuser
);
  import xsid_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("result item changed while stalled");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with empty result register");

  a_cond_only_jcc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != KIND_JCC |-> m_axis_tdata[CondLsb +: 4] == 4'd0)
    else $error("condition code set on a non-conditional item");

  a_imm_kinds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != KIND_DATA && m_axis_tuser != KIND_INTN
      && m_axis_tuser != KIND_MOV8 && m_axis_tuser != KIND_MOV16
      |-> m_axis_tdata[ImmLsb +: ImmWidth] == '0)
    else $error("immediate set on an item without one");

endmodule

bind x86_subset_insn_decoder xsid_checker u_xsid_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

FILE: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import xsid_pkg::*;

  localparam int RandomItems   = 1600;
  localparam int WatchdogLimit = 5000;
  localparam int LongHoldCycles = 300;
  localparam logic [19:0] MaxLength = 20'hfffff;

  localparam logic [7:0] DirectedCode [29] = '{
    OP_NOP, OP_RET, OP_RETF, OP_INT3, OP_INTN, 8'h21,
    OP_INC_LO, OP_DEC_HI, OP_PUSH_LO, OP_POP_HI,
    OP_MOV8_LO, 8'hff, OP_MOV16_HI, 8'h34, 8'h12,
    OP_CALL, 8'h00, 8'h80, OP_JMPN, 8'hff, 8'h7f,
    OP_JMPS, 8'h80, OP_JCC_LO, 8'h05, OP_JCC_HI, 8'hfe,
    8'h00, 8'hff
  };

  typedef struct packed {
    logic [19:0] addr;
    kind_e       kind;
    logic [2:0]  reg_no;
    logic [3:0]  cond;
    logic [15:0] imm;
    logic [21:0] target;
  } insn_rec_t;

  class insn_decode_model;
    logic [19:0] image_len;
    logic [19:0] offset;
    logic [19:0] held_addr;
    logic [1:0]  pending;
    logic [7:0]  held_op;
    logic [7:0]  held_lo;
    insn_rec_t   records[$];
    int          errors;

    function new();
      image_len = '0;
      offset    = '0;
      held_addr = '0;
      pending   = '0;
      held_op   = '0;
      held_lo   = '0;
      errors    = 0;
    endfunction

    static function logic [1:0] operand_len(logic [7:0] op);
      if (op == OP_INTN || op == OP_JMPS) return 2'd1;
      if (op >= OP_MOV8_LO && op <= OP_MOV8_HI) return 2'd1;
      if (op >= OP_JCC_LO && op <= OP_JCC_HI) return 2'd1;
      if (op >= OP_MOV16_LO && op <= OP_MOV16_HI) return 2'd2;
      if (op == OP_CALL || op == OP_JMPN) return 2'd2;
      return 2'd0;
    endfunction

    function void set_length(logic [19:0] v);
      image_len = v;
    endfunction

    function insn_rec_t complete_held(logic [7:0] last);
      insn_rec_t r;
      int d8;
      int d16;
      int a;
      int t;
      r   = '0;
      r.addr = held_addr;
      a   = held_addr;
      d8  = $signed(last);
      d16 = $signed({last, held_lo});
      t   = 0;
      if (held_op == OP_INTN) begin
        r.kind = KIND_INTN;
        r.imm  = {8'h00, last};
      end else if (held_op == OP_JMPS) begin
        r.kind = KIND_JMPS;
        t = a + 2 + d8;
      end else if (held_op >= OP_MOV8_LO && held_op <= OP_MOV8_HI) begin
        r.kind   = KIND_MOV8;
        r.reg_no = held_op[2:0];
        r.imm    = {8'h00, last};
      end else if (held_op >= OP_JCC_LO && held_op <= OP_JCC_HI) begin
        r.kind = KIND_JCC;
        r.cond = held_op[3:0];
        t = a + 2 + d8;
      end else if (held_op >= OP_MOV16_LO && held_op <= OP_MOV16_HI) begin
        r.kind   = KIND_MOV16;
        r.reg_no = held_op[2:0];
        r.imm    = {last, held_lo};
      end else if (held_op == OP_CALL) begin
        r.kind = KIND_CALL;
        t = a + 3 + d16;
      end else begin
        r.kind = KIND_JMPN;
        t = a + 3 + d16;
      end
      r.target = t[21:0];
      return r;
    endfunction

    function void take_code_byte(logic [7:0] b);
      insn_rec_t   r;
      logic [1:0]  need;
      logic [19:0] a;
      if (offset >= image_len) return;
      a = offset;
      offset = offset + 20'd1;
      if (pending == 2'd2) begin
        held_lo = b;
        pending = 2'd1;
        return;
      end
      if (pending != 2'd0) begin
        pending = 2'd0;
        records.push_back(complete_held(b));
        return;
      end
      r = '0;
      r.addr = a;
      need = operand_len(b);
      if (b == OP_NOP) begin
        r.kind = KIND_NOP;
      end else if (b == OP_RET) begin
        r.kind = KIND_RET;
      end else if (b == OP_RETF) begin
        r.kind = KIND_RETF;
      end else if (b == OP_INT3) begin
        r.kind = KIND_INT3;
      end else if (b >= OP_INC_LO && b <= OP_POP_HI) begin
        if (b <= OP_INC_HI) r.kind = KIND_INC;
        else if (b <= OP_DEC_HI) r.kind = KIND_DEC;
        else if (b <= OP_PUSH_HI) r.kind = KIND_PUSH;
        else r.kind = KIND_POP;
        r.reg_no = b[2:0];
      end else if (need != 2'd0 && int'(a) + 1 + int'(need) <= int'(image_len)) begin
        held_op   = b;
        held_addr = a;
        held_lo   = 8'h00;
        pending   = need;
        return;
      end else begin
        r.kind = KIND_DATA;
        r.imm  = {8'h00, b};
      end
      records.push_back(r);
    endfunction

    function void check_record(logic [OutWidth-1:0] d, logic [KindWidth-1:0] k);
      insn_rec_t e;
      if (records.size() == 0) begin
        $error("record with none pending: tdata %h tuser %h", d, k);
        errors++;
        return;
      end
      e = records.pop_front();
      if (d[AddrLsb +: AddrWidth] !== e.addr) begin
        $error("insn_address expected %h actual %h", e.addr, d[AddrLsb +: AddrWidth]);
        errors++;
      end
      if (k !== e.kind) begin
        $error("insn_kind expected %0d actual %0d", e.kind, k);
        errors++;
      end
      if (d[RegLsb +: 3] !== e.reg_no) begin
        $error("reg_index expected %0d actual %0d", e.reg_no, d[RegLsb +: 3]);
        errors++;
      end
      if (d[CondLsb +: 4] !== e.cond) begin
        $error("cond_code expected %0d actual %0d", e.cond, d[CondLsb +: 4]);
        errors++;
      end
      if (d[ImmLsb +: ImmWidth] !== e.imm) begin
        $error("immediate expected %h actual %h", e.imm, d[ImmLsb +: ImmWidth]);
        errors++;
      end
      if (d[TargetLsb +: TargetWidth] !== e.target) begin
        $error("branch_target expected %h actual %h", e.target, d[TargetLsb +: TargetWidth]);
        errors++;
      end
    endfunction

    function void report_leftover();
      if (records.size() != 0) begin
        $error("%0d instruction records never arrived", records.size());
        errors++;
      end
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_valid_i   = 1'b0;
  logic                 cfg_ready_o;
  logic [19:0]          cfg_data_i    = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [7:0]           s_axis_tdata  = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OutWidth-1:0]  m_axis_tdata;   // insn_address, reg_index, cond_code, immediate,
                                        // branch_target, zeros above
  logic [KindWidth-1:0] m_axis_tuser;   // insn_kind

  int send_idle_pct = 16;
  int recv_idle_pct = 47;
  bit long_hold_req = 1'b0;
  logic [7:0] code_fifo[$];

  insn_decode_model model = new();

  x86_subset_insn_decoder dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) model.check_record(m_axis_tdata, m_axis_tuser);
      if (cfg_valid_i && cfg_ready_o) model.set_length(cfg_data_i);
      if (s_axis_tvalid && s_axis_tready) model.take_code_byte(s_axis_tdata);
    end
  end

  initial begin
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else if (long_hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = LongHoldCycles;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WatchdogLimit) begin
      @(posedge clk_i);
      if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("Test completed with failures");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic write_length(input logic [19:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain_records();
    s_axis_tvalid <= 1'b0;
    while (model.records.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  initial begin
    int base;
    int len;
    int n;
    int useful;
    int sel;
    logic [7:0] op;
    logic [7:0] rnd;
    useful = 0;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // length zero: everything dropped
    repeat (2) send_byte(8'($urandom_range(0, 255)));
    drain_records();
    write_length('0);
    repeat (2) send_byte(8'($urandom_range(0, 255)));
    drain_records();

    write_length(MaxLength);
    foreach (DirectedCode[i]) send_byte(DirectedCode[i]);
    drain_records();

    // operands running past the end, and a held opcode across length writes
    base = model.offset;
    write_length(20'(base + 4));
    send_byte(OP_MOV16_LO);
    send_byte(8'h11);
    send_byte(8'h22);
    send_byte(OP_JMPN);
    send_byte(OP_NOP);
    drain_records();
    write_length(20'(base + 6));
    send_byte(OP_INTN);
    drain_records();
    write_length(20'(base + 5));
    send_byte(8'h33);
    drain_records();
    write_length(20'(base + 8));
    send_byte(8'h21);
    send_byte(OP_JCC_LO + 8'd3);
    send_byte(8'h80);
    drain_records();

    // hold the result side off while bytes keep coming
    send_idle_pct = 0;
    write_length(MaxLength);
    long_hold_req = 1'b1;
    repeat (60) send_byte(OP_PUSH_LO + 8'($urandom_range(0, 7)));
    drain_records();

    while (useful < RandomItems) begin
      case (useful * 3 / RandomItems)
        0: begin
          send_idle_pct = 16;
          recv_idle_pct = 47;
        end
        1: begin
          send_idle_pct = 47;
          recv_idle_pct = 16;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      base = model.offset;
      sel  = $urandom_range(0, 9);
      if (sel == 0) begin
        len = 0;
        n   = 3;
      end else if (sel == 1) begin
        len = MaxLength;
        n   = $urandom_range(10, 80);
      end else if (sel == 2) begin
        len = base;
        n   = 3;
      end else begin
        len = base + $urandom_range(1, 60);
        n   = len - base + $urandom_range(0, 4);
      end
      write_length(20'(len));
      for (int i = 0; i < n; i++) begin
        if (code_fifo.size() == 0) begin
          sel = $urandom_range(0, 13);
          case (sel)
            0:       op = OP_NOP;
            1:       op = OP_RET;
            2:       op = OP_RETF;
            3:       op = OP_INT3;
            4:       op = OP_INTN;
            5:       op = OP_INC_LO + 8'($urandom_range(0, 31));
            6:       op = OP_MOV8_LO + 8'($urandom_range(0, 7));
            7:       op = OP_MOV16_LO + 8'($urandom_range(0, 7));
            8:       op = OP_CALL;
            9:       op = OP_JMPN;
            10:      op = OP_JMPS;
            11:      op = OP_JCC_LO + 8'($urandom_range(0, 15));
            default: op = 8'($urandom_range(0, 255));
          endcase
          code_fifo.push_back(op);
          for (int j = 0; j < int'(insn_decode_model::operand_len(op)); j++) begin
            rnd = 8'($urandom_range(0, 255));
            code_fifo.push_back(rnd);
          end
        end
        if (base + i < len) useful++;
        send_byte(code_fifo.pop_front());
      end
      drain_records();
    end

    model.report_leftover();
    if (model.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/xsid_pkg.sv
rtl/x86_subset_insn_decoder.sv
rtl/xsid_checker.sv
tb/tb_top.sv
